FILE: hdl/ttps_pkg.sv
// shared types, constants and score helpers for the transposition table probe/store block
`timescale 1ns / 1ps

package ttps_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 65536;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int MOVE_BITS     = 16;

    // field widths fixed by the interface
    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 7;
    localparam int SCORE_W = 21;
    localparam int BOUND_W = 2;
    localparam int MOVEIO_W = 16;
    localparam int PLY_W   = 7;

    // request kinds
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_PROBE = 1'b1;

    // bound kinds
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

    // mate window and score saturation
    localparam int MATE      = 100000;
    localparam int MATE_ZONE = 1000;
    localparam int SAT_LIM   = 1 << 20;
    localparam logic signed [SCORE_W:0] MATE_EDGE = (SCORE_W + 1)'(MATE - MATE_ZONE);
    localparam logic signed [SCORE_W:0] S21_MAX   = (SCORE_W + 1)'(SAT_LIM - 1);
    localparam logic signed [SCORE_W:0] S21_MIN   = (SCORE_W + 1)'(-SAT_LIM);

    // one table slot
    typedef struct packed {
        logic                       valid;
        logic [KEY_W-1:0]           key;
        logic [DEPTH_W-1:0]         depth;
        logic signed [SCORE_W-1:0]  score;
        logic [BOUND_W-1:0]         bound;
        logic [MOVE_BITS-1:0]       move;
    } t_entry;

    // one request beat, unpacked
    typedef struct packed {
        logic                       probe;
        logic [KEY_W-1:0]           key;
        logic [DEPTH_W-1:0]         depth;
        logic signed [SCORE_W-1:0]  score;
        logic [BOUND_W-1:0]         bound;
        logic [MOVEIO_W-1:0]        move;
        logic signed [SCORE_W-1:0]  alpha;
        logic signed [SCORE_W-1:0]  beta;
        logic [PLY_W-1:0]           ply;
    } t_req;

    // one result beat, unpacked
    typedef struct packed {
        logic                       key_matched;
        logic                       cutoff;
        logic signed [SCORE_W-1:0]  score;
        logic [MOVEIO_W-1:0]        move;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic             accept;
        logic             eval;
        logic             clear_wr;
        logic [IDX_W-1:0] clear_addr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_probe;
        logic out_free;
    } t_sts;

    // push mate scores outward by ply (push=1) or pull them back (push=0), saturating
    function automatic logic signed [SCORE_W-1:0] mate_shift(
        input logic signed [SCORE_W-1:0] score,
        input logic [PLY_W-1:0]          ply,
        input logic                      push
    );
        logic signed [SCORE_W:0] s_w;
        logic signed [SCORE_W:0] p_w;
        logic signed [SCORE_W:0] r_w;
        s_w = {score[SCORE_W-1], score};
        p_w = signed'({{(SCORE_W + 1 - PLY_W){1'b0}}, ply});
        if (s_w > MATE_EDGE) begin
            r_w = push ? s_w + p_w : s_w - p_w;
        end else if (s_w < -MATE_EDGE) begin
            r_w = push ? s_w - p_w : s_w + p_w;
        end else begin
            r_w = s_w;
        end
        if (r_w > S21_MAX) begin
            r_w = S21_MAX;
        end else if (r_w < S21_MIN) begin
            r_w = S21_MIN;
        end
        return r_w[SCORE_W-1:0];
    endfunction

    // move as kept in the table
    function automatic logic [MOVE_BITS-1:0] move_keep(input logic [MOVEIO_W-1:0] m);
        logic [31:0] w;
        w = 32'(m);
        return w[MOVE_BITS-1:0];
    endfunction

    // move as returned on the port
    function automatic logic [MOVEIO_W-1:0] move_give(input logic [MOVE_BITS-1:0] m);
        logic [31:0] w;
        w = 32'(m);
        return w[MOVEIO_W-1:0];
    endfunction

endpackage

FILE: hdl/ttps_ctrl.sv
// sequencer: clearing pass after reset, request accept and evaluate steps
`timescale 1ns / 1ps

module ttps_ctrl
    import ttps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_clr_cnt;
    logic [IDX_W-1:0] n_clr_cnt;

    always_comb begin
        n_state          = r_state;
        n_clr_cnt        = r_clr_cnt;
        o_s_ready        = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.eval       = 1'b0;
        o_cmd.clear_wr   = 1'b0;
        o_cmd.clear_addr = r_clr_cnt;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                n_clr_cnt      = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // a probe waits here while the result register is still held
                if (!i_sts.req_probe || i_sts.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
        end
    end

endmodule

FILE: hdl/ttps_datapath.sv
// request register, slot memory, store/probe evaluation and result register
`timescale 1ns / 1ps

module ttps_datapath
    import ttps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    input  t_req    i_req,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out
);

    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rd;
    t_req             r_req;
    t_req             n_req;
    t_result          r_out;
    t_result          n_out;
    logic             r_out_valid;
    logic             n_out_valid;

    logic             w_hit_key;
    logic             w_store_ok;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;
    t_entry           w_new;
    logic             w_load;
    logic signed [SCORE_W-1:0] w_pscore;
    logic             w_bound_ok;
    logic             w_cutoff;

    // store score is ply-shifted as the request is taken
    always_comb begin
        n_req       = i_req;
        n_req.score = mate_shift(i_req.score, i_req.ply, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= n_req;
        end
    end

    // evaluation against the slot read at accept
    always_comb begin
        w_hit_key  = r_rd.valid && (r_rd.key == r_req.key);
        w_store_ok = !r_rd.valid || (r_req.depth >= r_rd.depth);
        w_pscore   = mate_shift(r_rd.score, r_req.ply, 1'b0);
        w_bound_ok = (r_rd.bound == BOUND_EXACT) ||
                     ((r_rd.bound == BOUND_UPPER) && (w_pscore <= r_req.alpha)) ||
                     ((r_rd.bound == BOUND_LOWER) && (w_pscore >= r_req.beta));
        w_cutoff   = w_hit_key && (r_rd.depth >= r_req.depth) && w_bound_ok;

        n_out.key_matched = w_hit_key;
        n_out.cutoff      = w_cutoff;
        n_out.score       = w_cutoff ? w_pscore : '0;
        n_out.move        = w_hit_key ? move_give(r_rd.move) : '0;

        w_new.valid = 1'b1;
        w_new.key   = r_req.key;
        w_new.depth = r_req.depth;
        w_new.score = r_req.score;
        w_new.bound = r_req.bound;
        w_new.move  = move_keep(r_req.move);

        w_we    = i_cmd.clear_wr || (i_cmd.eval && !r_req.probe && w_store_ok);
        w_waddr = i_cmd.clear_wr ? i_cmd.clear_addr : r_req.key[IDX_W-1:0];
        w_wdata = i_cmd.clear_wr ? '0 : w_new;
        w_load  = i_cmd.eval && r_req.probe;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.accept) begin
            r_rd <= r_mem[i_req.key[IDX_W-1:0]];
        end
    end

    // result register
    assign n_out_valid = w_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_sts.req_probe = r_req.probe;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    a_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear_wr && (i_cmd.accept || i_cmd.eval)))
        else $error("request handled during clearing pass");

    a_probe_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_req.probe) |-> (!r_out_valid || i_out_ready))
        else $error("probe result would overwrite a held result");

    a_probe_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_req.probe) |=> r_out_valid)
        else $error("probe evaluated but no result presented");

    a_cutoff_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.cutoff || r_out.key_matched))
        else $error("cutoff reported without key match");

    a_score_zero_no_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.cutoff) |-> (r_out.score == '0))
        else $error("nonzero score without cutoff");

endmodule

FILE: hdl/transposition_table_probe_store_top.sv
// top level of the transposition table probe/store block with stream ports
`timescale 1ns / 1ps

// Direct-mapped, depth-preferred transposition table of 65536 slots indexed by
// the low 16 bits of the position key. A request beat is either a store
// (tuser = 0) or a probe (tuser = 1); a store returns nothing, a probe returns
// one result beat. For each request the accept cycle reads the slot from
// the single table memory, and the evaluation step then either writes the
// slot back or loads the result register. A new request is not taken until
// the previous one is evaluated. A probe stays in evaluation while the
// previous result is still held downstream. After reset the table is cleared
// by a pass that writes one slot per cycle, during which s_axis tready stays
// low.

module transposition_table_probe_store_top
    import ttps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request channel
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // hash_key[63:0], search_depth[70:64], score_in[91:71], bound_kind[93:92],
    // move_in[109:94], window_low[130:110], window_high[151:131],
    // ply_from_root[158:152], zero[159]
    input  logic [159:0] i_s_axis_tdata,
    // req_type[0]
    input  logic [0:0]   i_s_axis_tuser,
    // result channel
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // score_out[20:0], move_out[36:21], zero[39:37]
    output logic [39:0]  o_m_axis_tdata,
    // key_matched[0], cutoff_hit[1]
    output logic [1:0]   o_m_axis_tuser
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_req    w_req;
    t_result w_out;

    // unpack the request beat
    always_comb begin
        w_req.probe = i_s_axis_tuser[0];
        w_req.key   = i_s_axis_tdata[63:0];
        w_req.depth = i_s_axis_tdata[70:64];
        w_req.score = i_s_axis_tdata[91:71];
        w_req.bound = i_s_axis_tdata[93:92];
        w_req.move  = i_s_axis_tdata[109:94];
        w_req.alpha = i_s_axis_tdata[130:110];
        w_req.beta  = i_s_axis_tdata[151:131];
        w_req.ply   = i_s_axis_tdata[158:152];
    end

    // sequencer: clearing pass, accept, evaluate
    ttps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // table memory, compare logic and result register
    ttps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (w_req),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (w_out)
    );

    // pack the result beat
    assign o_m_axis_tdata = {3'b000, w_out.move, w_out.score};
    assign o_m_axis_tuser = {w_out.cutoff, w_out.key_matched};

endmodule
